>>> rtl/polynomial_value_and_slope_core_defines.svh
// Assertion macros for the port-level checker file of the polynomial core.
// Depends on nothing; expects clk_i and rst_ni to be visible at the point of use.
`ifndef POLYNOMIAL_VALUE_AND_SLOPE_CORE_DEFINES_SVH
`define POLYNOMIAL_VALUE_AND_SLOPE_CORE_DEFINES_SVH

// Checked only while the block is out of reset.
`define PVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PVS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/pvs_pkg.sv
// Shared types, constants and Horner step arithmetic of the polynomial core.
// Used by pvs_cfg_regs, pvs_cell and the top level; depends on nothing.
`default_nettype none

package pvs_pkg;

  // Degree of the evaluated polynomial and number of coefficient registers.
  localparam int MaxDegree = 6;
  localparam int NumCoef   = 7;

  // Field and datapath widths.
  localparam int CoefW = 32;
  localparam int XW    = 32;
  localparam int AccW  = 48;
  localparam int TermW = 36;
  localparam int SumW  = 50;
  localparam int PartW = 56;
  localparam int AddrW = 5;
  localparam int IdxW  = 3;

  localparam logic signed [AccW-1:0] SatHi = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatLo = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [63:0] MagCap = 64'd1 << AccW;

  // One item as it travels down the row of cells.
  typedef struct packed {
    logic signed [XW-1:0]   x;
    logic signed [AccW-1:0] val;
    logic signed [AccW-1:0] slo;
    logic                   ovf;
  } pvs_item_t;

  // Partial products of one accumulator times x, split at bit 24.
  typedef struct packed {
    logic [PartW-1:0] hi;
    logic [PartW-1:0] lo;
    logic             neg;
  } pvs_part_t;

  // Result of one Horner step.
  typedef struct packed {
    logic signed [AccW-1:0] acc;
    logic                   ovf;
  } pvs_sum_t;

  // Sign-magnitude split of acc * x into two 24 by 32 bit products.
  function automatic pvs_part_t pvs_mul_split(logic signed [AccW-1:0] a,
                                              logic signed [XW-1:0] x);
    logic [AccW-1:0] am;
    logic [XW-1:0]   xm;
    pvs_part_t       p;
    am    = a[AccW-1] ? AccW'(-a) : AccW'(a);
    xm    = x[XW-1] ? XW'(-x) : XW'(x);
    p.neg = a[AccW-1] ^ x[XW-1];
    p.hi  = am[AccW-1:24] * xm;
    p.lo  = am[23:0] * xm;
    return p;
  endfunction

  // Combine the partials with a floor shift by 16, add the term and saturate.
  function automatic pvs_sum_t pvs_step(pvs_part_t p, logic signed [TermW-1:0] term);
    logic [PartW:0]         lo_r;
    logic [63:0]            mag;
    logic [AccW:0]          mag_c;
    logic signed [SumW-1:0] prod;
    logic signed [SumW-1:0] sum;
    pvs_sum_t               r;
    lo_r  = {1'b0, p.lo} + (p.neg ? (PartW+1)'(16'hFFFF) : '0);
    mag   = {p.hi, 8'h00} + 64'(lo_r[PartW:16]);
    mag_c = (mag > MagCap) ? MagCap[AccW:0] : mag[AccW:0];
    prod  = p.neg ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    sum   = prod + SumW'(term);
    if (sum > SumW'(SatHi)) begin
      r.acc = SatHi;
      r.ovf = 1'b1;
    end else if (sum < SumW'(SatLo)) begin
      r.acc = SatLo;
      r.ovf = 1'b1;
    end else begin
      r.acc = sum[AccW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // Coefficient scaled by its exponent for the slope chain.
  function automatic logic signed [TermW-1:0] pvs_scale(logic signed [CoefW-1:0] c, int k);
    logic signed [TermW-1:0] kk;
    kk = TermW'(k);
    return TermW'(c) * kk;
  endfunction

endpackage

`default_nettype wire

>>> rtl/polynomial_value_and_slope_core.sv
// Polynomial value and slope core: for each Q16.16 sample x it returns p(x) and
// p'(x) in Q32.16, saturated, with a flag that is set when any Horner step clamped.
// A row of MaxDegree cells evaluates both Horner chains; each cell is two stages
// (partial products, then round/add/saturate). A new item may enter every cycle
// while the output is not stalled; stalls propagate only as far back as the first
// empty stage. Coefficients are written through the APB-style port at byte address
// 4*k for coef_k; the user must write them only while no items are in flight, and
// the block does not enforce this. Depends on pvs_pkg, pvs_cfg_regs and pvs_cell.
`default_nettype none

module polynomial_value_and_slope_core
  import pvs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [AddrW-1:0]       paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [XW-1:0]   x_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [AccW-1:0] poly_value_o,
  output logic signed [AccW-1:0] poly_slope_o,
  output logic                   overflow_o
);

  logic signed [CoefW-1:0] coef [NumCoef];
  logic signed [TermW-1:0] term [NumCoef];
  logic                    lnk_valid [MaxDegree+1];
  logic                    lnk_ready [MaxDegree+1];
  pvs_item_t               lnk_item  [MaxDegree+1];

  pvs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef),
    .term_o  (term)
  );

  // Horner chains start from the leading coefficient.
  assign lnk_valid[0]    = in_valid_i;
  assign lnk_item[0].x   = x_in_i;
  assign lnk_item[0].val = AccW'(coef[MaxDegree]);
  assign lnk_item[0].slo = AccW'(term[MaxDegree]);
  assign lnk_item[0].ovf = 1'b0;
  assign in_stall_o      = !lnk_ready[0];

  // Cell j folds in the coefficient of exponent MaxDegree-1-j.
  for (genvar j = 0; j < MaxDegree; j++) begin : g_cell
    localparam int K = MaxDegree - 1 - j;
    pvs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (lnk_valid[j]),
      .in_item_i   (lnk_item[j]),
      .in_ready_o  (lnk_ready[j]),
      .out_valid_o (lnk_valid[j+1]),
      .out_item_o  (lnk_item[j+1]),
      .out_ready_i (lnk_ready[j+1]),
      .coef_i      (coef[K]),
      .term_i      (term[K]),
      .slope_en_i  ((K >= 1) ? 1'b1 : 1'b0)
    );
  end

  // The last cell's second stage is the output register.
  assign lnk_ready[MaxDegree] = !out_stall_i;
  assign out_valid_o          = lnk_valid[MaxDegree];
  assign poly_value_o         = lnk_item[MaxDegree].val;
  assign poly_slope_o         = lnk_item[MaxDegree].slo;
  assign overflow_o           = lnk_item[MaxDegree].ovf;

endmodule

`default_nettype wire

>>> rtl/pvs_cfg_regs.sv
// Coefficient register file behind the APB-style configuration port.
// Depends on pvs_pkg; also supplies the exponent-scaled slope terms.
`default_nettype none

module pvs_cfg_regs
  import pvs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output logic signed [CoefW-1:0] coef_o [NumCoef],
  output logic signed [TermW-1:0] term_o [NumCoef]
);

  logic signed [CoefW-1:0] coef_q [NumCoef];
  logic [IdxW-1:0]         idx;
  logic                    idx_ok;

  // Register index from the word address; indexes past the list are ignored.
  assign idx    = paddr[IdxW+1:2];
  assign idx_ok = (32'(idx) < NumCoef);
  assign pready = 1'b1;

  // Write on the access phase of a write transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoef; i++) coef_q[i] <= '0;
    end else if (psel && penable && pwrite && pready && idx_ok) begin
      coef_q[idx] <= pwdata;
    end
  end

  // Read back the addressed coefficient.
  assign prdata = idx_ok ? 32'(coef_q[idx]) : '0;

  // Coefficients and their exponent-scaled copies for the cells.
  always_comb begin
    for (int i = 0; i < NumCoef; i++) begin
      coef_o[i] = coef_q[i];
      term_o[i] = pvs_scale(coef_q[i], i);
    end
  end

endmodule

`default_nettype wire

>>> rtl/pvs_cell.sv
// One Horner cell: a step of the value chain and of the slope chain.
// Depends on pvs_pkg; two register stages, partial products then combine.
`default_nettype none

module pvs_cell
  import pvs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  pvs_item_t               in_item_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  output pvs_item_t               out_item_o,
  input  logic                    out_ready_i,
  input  logic signed [CoefW-1:0] coef_i,
  input  logic signed [TermW-1:0] term_i,
  input  logic                    slope_en_i
);

  logic                   va_q, vb_q;
  pvs_part_t              pv_q, ps_q;
  logic signed [XW-1:0]   xa_q;
  logic signed [AccW-1:0] slo_a_q;
  logic                   ovf_a_q;
  pvs_item_t              item_q, item_d;
  logic                   load_a, load_b;
  pvs_sum_t               sv, ss;

  // A stage loads when it is empty or its contents move on.
  assign load_b     = !vb_q || out_ready_i;
  assign load_a     = !va_q || load_b;
  assign in_ready_o = load_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (load_a) va_q <= in_valid_i;
      if (load_b) vb_q <= va_q;
    end
  end

  // First stage: partial products of both accumulators times x.
  always_ff @(posedge clk_i) begin
    if (load_a && in_valid_i) begin
      pv_q    <= pvs_mul_split(in_item_i.val, in_item_i.x);
      ps_q    <= pvs_mul_split(in_item_i.slo, in_item_i.x);
      xa_q    <= in_item_i.x;
      slo_a_q <= in_item_i.slo;
      ovf_a_q <= in_item_i.ovf;
    end
  end

  // Second stage: round, add the coefficient terms and saturate.
  always_comb begin
    sv         = pvs_step(pv_q, TermW'(coef_i));
    ss         = pvs_step(ps_q, term_i);
    item_d.x   = xa_q;
    item_d.val = sv.acc;
    item_d.slo = slope_en_i ? ss.acc : slo_a_q;
    item_d.ovf = ovf_a_q | sv.ovf | (slope_en_i & ss.ovf);
  end

  always_ff @(posedge clk_i) begin
    if (load_b && va_q) item_q <= item_d;
  end

  assign out_valid_o = vb_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

>>> rtl/pvs_checker.sv
// Port-level checks of the polynomial core, bound to the top level.
// Depends on polynomial_value_and_slope_core_defines.svh for the assertion macros.
`default_nettype none

`include "polynomial_value_and_slope_core_defines.svh"

module pvs_core_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [47:0] poly_value_o,
  input logic [47:0] poly_slope_o,
  input logic        overflow_o
);

  // A stalled result stays put until it is taken.
  `PVS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(poly_value_o) && $stable(poly_slope_o) && $stable(overflow_o), "result changed while stalled")

  // The input side only stalls when a finished result is blocked.
  `PVS_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with output free")

  // Reset empties the row of cells at once.
  `PVS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind polynomial_value_and_slope_core pvs_core_checker u_pvs_checker (.*);

`default_nettype wire

>>> dv/pvs_checker.sv
`timescale 1ns / 100ps
// Checker for the polynomial value and slope core: tracks coefficient writes,
// predicts p(x) and p'(x) for every accepted item and compares the results in order.
// Depends on pvs_pkg for widths and the register count.

module pvs_checker
  import pvs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic [AddrW-1:0]       paddr_i,
  input  logic [31:0]            pwdata_i,
  input  logic [31:0]            prdata_i,
  input  logic                   pready_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic signed [XW-1:0]   x_in_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic signed [AccW-1:0] poly_value_i,
  input  logic signed [AccW-1:0] poly_slope_i,
  input  logic                   overflow_i,
  output int                     pending_o,
  output int                     error_count_o,
  output int                     result_count_o,
  output int                     overflow_count_o,
  output int                     read_count_o
);

  // Wide signed arithmetic: a 48 bit accumulator times a 32 bit sample fits easily.
  localparam logic signed [95:0] ProdCap = 96'sh1000000000000;
  localparam logic signed [95:0] AccMax  = 96'sh7FFFFFFFFFFF;
  localparam logic signed [95:0] AccMin  = -96'sh800000000000;
  localparam int                 MaxReports = 10;

  typedef struct packed {
    logic [AccW-1:0] value;
    logic [AccW-1:0] slope;
    logic            ovf;
  } poly_result_t;

  typedef struct packed {
    logic [95:0] acc;
    logic        clamped;
  } horner_acc_t;

  logic signed [CoefW-1:0] coef_q [NumCoef];
  poly_result_t            expected_q [$];

  // One Horner step: floor(acc * x / 2^16), magnitude capped at 2^48, plus the
  // term, then clamped to the 48 bit range.
  function automatic horner_acc_t horner_step(logic signed [95:0] acc,
                                              logic signed [95:0] x,
                                              logic signed [95:0] term);
    logic signed [95:0] prod;
    horner_acc_t        r;
    prod = (acc * x) >>> 16;
    if (prod > ProdCap) begin
      prod = ProdCap;
    end else if (prod < -ProdCap) begin
      prod = -ProdCap;
    end
    prod = prod + term;
    r.clamped = 1'b1;
    if (prod > AccMax) begin
      r.acc = AccMax;
    end else if (prod < AccMin) begin
      r.acc = AccMin;
    end else begin
      r.acc     = prod;
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  // Value and slope of the polynomial at one sample, with the sticky clamp flag.
  function automatic poly_result_t eval_poly(logic signed [XW-1:0] x_raw);
    logic signed [95:0] x;
    logic signed [95:0] val;
    logic signed [95:0] slo;
    logic signed [95:0] cw;
    horner_acc_t        s;
    poly_result_t       r;
    x     = x_raw;
    r.ovf = 1'b0;
    val   = coef_q[MaxDegree];
    for (int k = MaxDegree - 1; k >= 0; k--) begin
      cw    = coef_q[k];
      s     = horner_step(val, x, cw);
      val   = $signed(s.acc);
      r.ovf = r.ovf | s.clamped;
    end
    cw  = coef_q[MaxDegree];
    slo = cw * 96'(MaxDegree);
    for (int k = MaxDegree - 1; k >= 1; k--) begin
      cw    = coef_q[k];
      s     = horner_step(slo, x, cw * 96'(k));
      slo   = $signed(s.acc);
      r.ovf = r.ovf | s.clamped;
    end
    r.value = val[AccW-1:0];
    r.slope = slo[AccW-1:0];
    return r;
  endfunction

  // Register shadow, prediction on input items and in-order comparison of results.
  always @(posedge clk_i or negedge rst_ni) begin
    poly_result_t want;
    poly_result_t got;
    int           idx;
    if (!rst_ni) begin
      for (int k = 0; k < NumCoef; k++) begin
        coef_q[k] = '0;
      end
      expected_q.delete();
      pending_o        = 0;
      error_count_o    = 0;
      result_count_o   = 0;
      overflow_count_o = 0;
      read_count_o     = 0;
    end else begin
      idx = int'(paddr_i[AddrW-1:2]);
      // Register access phase; indexes past the last coefficient are ignored.
      if (psel_i && penable_i && pready_i && idx < NumCoef) begin
        if (pwrite_i) begin
          coef_q[idx] = pwdata_i;
        end else begin
          read_count_o++;
          if (prdata_i !== coef_q[idx]) begin
            error_count_o++;
            if (error_count_o <= MaxReports) begin
              $display("%0t: coef_%0d read back %h, expected %h", $time, idx, prdata_i,
                       coef_q[idx]);
            end
          end
        end
      end
      // Result side is checked before the new item is predicted.
      if (out_valid_i && !out_stall_i) begin
        got.value = poly_value_i;
        got.slope = poly_slope_i;
        got.ovf   = overflow_i;
        result_count_o++;
        if (got.ovf === 1'b1) begin
          overflow_count_o++;
        end
        if (expected_q.size() == 0) begin
          error_count_o++;
          if (error_count_o <= MaxReports) begin
            $display("%0t: result with no item pending: value %h slope %h overflow %b",
                     $time, got.value, got.slope, got.ovf);
          end
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value || got.slope !== want.slope || got.ovf !== want.ovf)
          begin
            error_count_o++;
            if (error_count_o <= MaxReports) begin
              $display("%0t: mismatch: value exp %h got %h, slope exp %h got %h, ",
                       $time, want.value, got.value, want.slope, got.slope,
                       "overflow exp %b got %b", want.ovf, got.ovf);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(eval_poly(x_in_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> dv/tb_polynomial_value_and_slope_core.sv
`timescale 1ns / 100ps
// Testbench top for the polynomial value and slope core: drives samples and
// coefficient writes, varies both handshakes and gives the verdict.
// Depends on pvs_pkg, the core and pvs_checker.

module tb_polynomial_value_and_slope_core;
  import pvs_pkg::*;

  localparam int LimitNs     = 2_000_000;
  localparam int LongHold    = 400;
  localparam int RandPhases  = 8;
  localparam int PhaseItems  = 125;
  localparam int PressPhase  = 3;
  localparam int BeyondIdx   = NumCoef;
  localparam logic [31:0] QMax = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin = 32'h8000_0000;
  localparam logic [31:0] QOne = 32'h0001_0000;

  typedef enum int {
    CoefSmall,
    CoefMixed,
    CoefExtreme
  } coef_style_e;

  logic                   clk;
  logic                   rst_n;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [AddrW-1:0]       paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [XW-1:0]   x_in;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [AccW-1:0] poly_value;
  logic signed [AccW-1:0] poly_slope;
  logic                   overflow;

  int          pending;
  int          error_count;
  int          result_count;
  int          overflow_count;
  int          read_count;
  logic        hold_request;
  int          samples_sent;
  int          settings_used;
  logic [31:0] sample_q [$];

  polynomial_value_and_slope_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .x_in_i       (x_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .poly_value_o (poly_value),
    .poly_slope_o (poly_slope),
    .overflow_o   (overflow)
  );

  pvs_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .pready_i         (pready),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .x_in_i           (x_in),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .poly_value_i     (poly_value),
    .poly_slope_i     (poly_slope),
    .overflow_i       (overflow),
    .pending_o        (pending),
    .error_count_o    (error_count),
    .result_count_o   (result_count),
    .overflow_count_o (overflow_count),
    .read_count_o     (read_count)
  );

  // 100 MHz clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LimitNs);
    $display("tb_polynomial_value_and_slope_core: FAIL");
    $finish;
  end

  // Output stall pattern: segments of random style, plus one long hold on request.
  initial begin
    int seg_left;
    int mode;
    int hold_left;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHold;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        mode     = $urandom_range(0, 3);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 9) < 6);
          end
          default: begin
            out_stall <= (seg_left % 4 == 0);
          end
        endcase
      end
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input int idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read back every coefficient; the checker compares the data.
  task automatic read_coefs();
    for (int k = 0; k < NumCoef; k++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= AddrW'(k * 4);
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  function automatic logic [31:0] pick_coef(input coef_style_e style);
    int r;
    r = $urandom_range(0, 99);
    if (style == CoefExtreme) begin
      return (r < 50) ? QMax : QMin;
    end
    if (style == CoefSmall || r < 45) begin
      return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    end
    if (r < 55) begin
      return '0;
    end
    if (r < 80) begin
      return $urandom;
    end
    if (r < 90) begin
      return (r < 85) ? QMax : QMin;
    end
    return (r < 95) ? QOne : -QOne;
  endfunction

  function automatic logic [31:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return $urandom;
    end
    if (r < 60) begin
      return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
    end
    if (r < 85) begin
      return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    end
    case (r % 5)
      0: return QMax;
      1: return QMin;
      2: return '0;
      3: return QOne;
      default: return -QOne;
    endcase
  endfunction

  // Load a full coefficient set; the index past the last one must be ignored.
  task automatic load_coefs(input coef_style_e style);
    for (int k = 0; k < NumCoef; k++) begin
      write_reg(k, pick_coef(style));
    end
    write_reg(BeyondIdx, $urandom);
    settings_used++;
  endtask

  task automatic load_uniform(input logic [31:0] c);
    for (int k = 0; k < NumCoef; k++) begin
      write_reg(k, c);
    end
    settings_used++;
  endtask

  // Offer the queued samples in bursts with random gaps between them.
  task automatic drive_samples(input int gap_max);
    int burst_left;
    int gap;
    burst_left = 0;
    samples_sent += sample_q.size();
    while (sample_q.size() > 0) begin
      @(negedge clk);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_valid <= 1'b1;
      x_in     <= sample_q.pop_front();
      burst_left--;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every pending result, then let the pipeline go quiet.
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (2 * MaxDegree) @(negedge clk);
  endtask

  // Directed extremes of x used under the uniform coefficient sets.
  task automatic queue_edge_samples();
    sample_q.push_back(32'h0000_0000);
    sample_q.push_back(32'h0000_0001);
    sample_q.push_back(32'hFFFF_FFFF);
    sample_q.push_back(QOne);
    sample_q.push_back(-QOne);
    sample_q.push_back(QMax);
    sample_q.push_back(QMin);
    sample_q.push_back(32'h0000_8000);
    sample_q.push_back(32'h0001_8000);
    sample_q.push_back(32'hFFFE_8000);
  endtask

  // Main sequence.
  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    x_in          = '0;
    hold_request  = 1'b0;
    samples_sent  = 0;
    settings_used = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset coefficients are all zero.
    sample_q.push_back('0);
    sample_q.push_back(QMax);
    sample_q.push_back(QMin);
    sample_q.push_back(QOne);
    drive_samples(2);
    settle();
    read_coefs();

    // Largest and smallest coefficients everywhere: heavy intermediate clamping.
    load_uniform(QMax);
    write_reg(BeyondIdx, QMin);
    queue_edge_samples();
    drive_samples(3);
    settle();
    read_coefs();
    load_uniform(QMin);
    queue_edge_samples();
    drive_samples(3);
    settle();

    // Random coefficient sets and samples; one phase holds the output back for long.
    for (int phase = 0; phase < RandPhases; phase++) begin
      if (phase == 0) begin
        load_coefs(CoefSmall);
      end else if (phase == RandPhases - 1) begin
        load_coefs(CoefExtreme);
      end else begin
        load_coefs(CoefMixed);
      end
      read_coefs();
      repeat (PhaseItems) sample_q.push_back(pick_sample());
      if (phase == PressPhase) begin
        hold_request = 1'b1;
        drive_samples(0);
      end else begin
        drive_samples((phase % 2 == 1) ? 8 : 2);
      end
      settle();
    end

    repeat (2 * MaxDegree + 4) @(negedge clk);
    $display("Covered %0d samples over %0d coefficient sets: %0d results, %0d with overflow,",
             samples_sent, settings_used, result_count, overflow_count);
    $display("%0d register read-backs; %0d failures, %0d results still pending.",
             read_count, error_count, pending);
    if (error_count == 0 && pending == 0) begin
      $display("tb_polynomial_value_and_slope_core: PASS");
    end else begin
      $display("tb_polynomial_value_and_slope_core: FAIL");
    end
    $finish;
  end

endmodule

>>> polynomial_value_and_slope_core.f
+incdir+rtl
rtl/pvs_pkg.sv
rtl/pvs_cfg_regs.sv
rtl/pvs_cell.sv
rtl/polynomial_value_and_slope_core.sv
rtl/pvs_checker.sv
dv/pvs_checker.sv
dv/tb_polynomial_value_and_slope_core.sv
